// File: design/cq_pkg.sv
// ----------------------------------------------------------------------------
// cq_pkg
// Shared widths, codes and controller/datapath bundles of the circular queue.
// ----------------------------------------------------------------------------
`default_nettype none

package cq_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CAP_W  = 7;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_DISP = 2'd3
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    enq;
    logic    deq;
    logic    rd_head;
    logic    rd_next;
    logic    ld_err;
    logic    ld_enq;
    logic    ld_ram;
    logic    disp;
    status_e err_code;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic full;
    logic walk_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: design/cq_in_if.sv
// ----------------------------------------------------------------------------
// cq_in_if
// Request channel: opcode and value under a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cq_in_if;
  logic                              valid;
  logic                              ready;
  logic [cq_pkg::OP_W-1:0]           opcode;
  logic signed [cq_pkg::WORD_W-1:0]  value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

// File: design/cq_out_if.sv
// ----------------------------------------------------------------------------
// cq_out_if
// Result channel: status, data and queue flags under a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cq_out_if;
  logic                              valid;
  logic                              ready;
  logic [cq_pkg::STAT_W-1:0]         status;
  logic signed [cq_pkg::WORD_W-1:0]  data;
  logic                              is_empty;
  logic                              is_full;
  logic                              last;

  modport source (output valid, output status, output data, output is_empty,
                  output is_full, output last, input ready);
  modport sink   (input valid, input status, input data, input is_empty,
                  input is_full, input last, output ready);
endinterface

`default_nettype wire

// File: design/cq_cfg_if.sv
// ----------------------------------------------------------------------------
// cq_cfg_if
// Configuration write channel for the capacity register.
// ----------------------------------------------------------------------------
`default_nettype none

interface cq_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [cq_pkg::CAP_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

`default_nettype wire

// File: design/circular_queue.sv
// ----------------------------------------------------------------------------
// circular_queue
// Circular FIFO of signed 32-bit words with a programmable capacity.
// ----------------------------------------------------------------------------
// Channels: in_i takes requests (opcode, value), out_o gives results (status,
// data, is_empty, is_full, last), cfg_i writes the capacity register. Writing
// the capacity also empties the queue; cfg_i is always ready. The user must
// see that cfg_i is written only while no request is in flight; the block
// does not enforce this. One request is handled at a time. Enqueue and every
// error give a single result in the cycle after the request transfer. Dequeue
// and peek read the slot RAM first and show their result through the
// registered RAM read and then the result register. Display shows each word
// the same way, the first after the request transfer and each further one
// after the previous result transfer; last marks the newest word.
// in_i is ready again the cycle after the final result transfers.
// A stalled receiver holds the result in the output register; nothing else
// moves until it transfers. Reset empties the queue and sets the capacity to
// DEPTH; slot contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_queue #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cq_in_if.sink     in_i,
  cq_out_if.source  out_o,
  cq_cfg_if.sink    cfg_i
);

  cq_pkg::dp_cmd_t  cmd;
  cq_pkg::dp_stat_t stat;

  assign cfg_i.ready = 1'b1;

  cq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .opcode_i    (in_i.opcode),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_cap_i  (cfg_i.capacity),
    .value_i    (in_i.value),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .status_o   (out_o.status),
    .data_o     (out_o.data),
    .is_empty_o (out_o.is_empty),
    .is_full_o  (out_o.is_full),
    .last_o     (out_o.last)
  );

endmodule

`default_nettype wire

// File: design/cq_ram.sv
// ----------------------------------------------------------------------------
// cq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/cq_ctrl.sv
// ----------------------------------------------------------------------------
// cq_ctrl
// Controller: takes one request at a time, sequences slot reads and results.
// ----------------------------------------------------------------------------
`default_nettype none

module cq_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  input  wire logic [cq_pkg::OP_W-1:0] opcode_i,
  output logic                         in_ready_o,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  input  wire cq_pkg::dp_stat_t        stat_i,
  output cq_pkg::dp_cmd_t              cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   disp_q, disp_d;

  always_comb begin
    state_d      = state_q;
    disp_d       = disp_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o        = '0;
    cmd_o.err_code = cq_pkg::ST_OK;
    cmd_o.disp   = disp_q;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          disp_d = 1'b0;
          unique case (cq_pkg::opcode_e'(opcode_i))
            cq_pkg::OP_ENQ: begin
              if (stat_i.full) begin
                cmd_o.ld_err   = 1'b1;
                cmd_o.err_code = cq_pkg::ST_OVERFLOW;
              end else begin
                cmd_o.enq    = 1'b1;
                cmd_o.ld_enq = 1'b1;
              end
              state_d = S_OUT;
            end
            cq_pkg::OP_DEQ, cq_pkg::OP_PEEK, cq_pkg::OP_DISP: begin
              if (stat_i.empty) begin
                cmd_o.ld_err   = 1'b1;
                cmd_o.err_code = cq_pkg::ST_EMPTY;
                state_d        = S_OUT;
              end else begin
                cmd_o.rd_head = 1'b1;
                cmd_o.deq     = (cq_pkg::opcode_e'(opcode_i) == cq_pkg::OP_DEQ);
                disp_d        = (cq_pkg::opcode_e'(opcode_i) == cq_pkg::OP_DISP);
                state_d       = S_READ;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        cmd_o.ld_ram = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          // display walks on until the newest word has gone out
          if (disp_q && !stat_i.walk_last) begin
            cmd_o.rd_next = 1'b1;
            state_d       = S_READ;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      disp_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      disp_q  <= disp_d;
    end
  end

endmodule

`default_nettype wire

// File: design/cq_datapath.sv
// ----------------------------------------------------------------------------
// cq_datapath
// Head, tail and walk pointers, capacity, slot RAM and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cq_datapath #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [cq_pkg::CAP_W-1:0]          cfg_cap_i,
  input  wire logic signed [cq_pkg::WORD_W-1:0]  value_i,
  input  wire cq_pkg::dp_cmd_t                   cmd_i,
  output cq_pkg::dp_stat_t                       stat_o,
  output logic [cq_pkg::STAT_W-1:0]              status_o,
  output logic signed [cq_pkg::WORD_W-1:0]       data_o,
  output logic                                   is_empty_o,
  output logic                                   is_full_o,
  output logic                                   last_o
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [IDX_W-1:0] head_q, tail_q, walk_q;
  logic [IDX_W-1:0] head_nxt, tail_nxt, walk_nxt;
  logic [CNT_W-1:0] cap_q, cap_eff;
  logic             empty_q, full;

  cq_pkg::status_e                  status_q;
  logic signed [cq_pkg::WORD_W-1:0] data_q;
  logic                             last_q;

  logic                       ram_we, ram_re;
  logic [IDX_W-1:0]           ram_waddr, ram_raddr;
  logic [cq_pkg::WORD_W-1:0]  ram_rdata;

  // step an index and wrap it at the capacity
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(idx) + CNT_W'(1);
    if (inc == cap) begin
      return '0;
    end
    return inc[IDX_W-1:0];
  endfunction

  assign head_nxt = next_idx(head_q, cap_q);
  assign tail_nxt = next_idx(tail_q, cap_q);
  assign walk_nxt = next_idx(walk_q, cap_q);
  assign full     = !empty_q && (tail_nxt == head_q);

  // zero reads as one, anything above the slot count saturates
  always_comb begin
    if (cfg_cap_i == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cfg_cap_i > cq_pkg::CAP_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = cfg_cap_i[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      walk_q  <= '0;
      empty_q <= 1'b1;
      cap_q   <= CNT_W'(DEPTH);
    end else if (cfg_we_i) begin
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
      cap_q   <= cap_eff;
    end else begin
      if (cmd_i.enq) begin
        if (empty_q) begin
          head_q  <= '0;
          tail_q  <= '0;
          empty_q <= 1'b0;
        end else begin
          tail_q <= tail_nxt;
        end
      end
      if (cmd_i.deq) begin
        if (head_q == tail_q) begin
          head_q  <= '0;
          tail_q  <= '0;
          empty_q <= 1'b1;
        end else begin
          head_q <= head_nxt;
        end
      end
      if (cmd_i.rd_head) begin
        walk_q <= head_q;
      end else if (cmd_i.rd_next) begin
        walk_q <= walk_nxt;
      end
    end
  end

  assign ram_we    = cmd_i.enq;
  assign ram_waddr = empty_q ? '0 : tail_nxt;
  assign ram_re    = cmd_i.rd_head | cmd_i.rd_next;
  assign ram_raddr = cmd_i.rd_head ? head_q : walk_nxt;

  cq_ram #(
    .WIDTH (cq_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_err) begin
      status_q <= cmd_i.err_code;
      data_q   <= '0;
      last_q   <= 1'b1;
    end else if (cmd_i.ld_enq) begin
      status_q <= cq_pkg::ST_OK;
      data_q   <= value_i;
      last_q   <= 1'b1;
    end else if (cmd_i.ld_ram) begin
      status_q <= cq_pkg::ST_OK;
      data_q   <= ram_rdata;
      last_q   <= !cmd_i.disp || (walk_q == tail_q);
    end
  end

  assign stat_o.empty     = empty_q;
  assign stat_o.full      = full;
  assign stat_o.walk_last = (walk_q == tail_q);

  // pointers are settled while a result waits, so the flags are live
  assign status_o   = status_q;
  assign data_o     = data_q;
  assign last_o     = last_q;
  assign is_empty_o = empty_q;
  assign is_full_o  = full;

endmodule

`default_nettype wire

// File: design/cq_checker.sv
// ----------------------------------------------------------------------------
// cq_checker
// Port-level checks of the circular queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cq_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [cq_pkg::STAT_W-1:0]         status,
  input wire logic signed [cq_pkg::WORD_W-1:0]  data,
  input wire logic                              is_empty,
  input wire logic                              is_full,
  input wire logic                              last
);

  // one request at a time: no new request while a result is pending
  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("request accepted while a result is pending");

  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (status != cq_pkg::ST_OK) |-> (data == '0) && last)
    else $error("error result without zero data and last");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (status == cq_pkg::ST_OVERFLOW) |-> is_full && !is_empty)
    else $error("overflow reported on a queue that is not full");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (status == cq_pkg::ST_EMPTY) |-> is_empty && !is_full)
    else $error("empty status reported on a queue that holds words");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(data) && $stable(last))
    else $error("stalled result changed");

endmodule

bind circular_queue cq_checker u_cq_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .status    (out_o.status),
  .data      (out_o.data),
  .is_empty  (out_o.is_empty),
  .is_full   (out_o.is_full),
  .last      (out_o.last)
);

`default_nettype wire
